FILE: src/kat_pkg.sv
// Shared types, constants and table functions for the knee assist torque delay block.
// Used by kat_mul, kat_dline and knee_assist_torque_delay_top.
package kat_pkg;

  typedef enum logic [2:0] {
    REG_LEFT_OFFSET  = 3'd0,
    REG_RIGHT_OFFSET = 3'd1,
    REG_EXT_GAIN     = 3'd2,
    REG_FLEX_GAIN    = 3'd3,
    REG_DELAY_POINTS = 3'd4
  } cfg_reg_t;

  localparam int MUL_AW = 23;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int WALK_W = 18;
  localparam int DIFF_W = 23;
  localparam int STAIR_W = 20;
  localparam int LINE_W = WALK_W + DIFF_W + 2 * STAIR_W;

  localparam logic signed [22:0] FULL_TURN = 23'sd92160;
  localparam logic signed [22:0] BAND_LIMIT = 23'sd30720;
  localparam logic signed [16:0] COEF_KEEP = 17'sd62259;
  localparam logic signed [16:0] COEF_NEW = 17'sd3277;

  typedef struct packed {
    logic signed [WALK_W-1:0]  walk;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [STAIR_W-1:0] stair_l;
    logic signed [STAIR_W-1:0] stair_r;
  } line_entry_t;

  // round(32768 * sin(i degrees)) for i in 0..90.
  function automatic logic [15:0] quarter_sine(input logic [6:0] i);
    logic [15:0] v;
    case (i)
      7'd0: v = 16'd0;        7'd1: v = 16'd572;      7'd2: v = 16'd1144;
      7'd3: v = 16'd1715;     7'd4: v = 16'd2286;     7'd5: v = 16'd2856;
      7'd6: v = 16'd3425;     7'd7: v = 16'd3993;     7'd8: v = 16'd4560;
      7'd9: v = 16'd5126;     7'd10: v = 16'd5690;    7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;    7'd13: v = 16'd7371;    7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;    7'd16: v = 16'd9032;    7'd17: v = 16'd9580;
      7'd18: v = 16'd10126;   7'd19: v = 16'd10668;   7'd20: v = 16'd11207;
      7'd21: v = 16'd11743;   7'd22: v = 16'd12275;   7'd23: v = 16'd12803;
      7'd24: v = 16'd13328;   7'd25: v = 16'd13848;   7'd26: v = 16'd14365;
      7'd27: v = 16'd14876;   7'd28: v = 16'd15384;   7'd29: v = 16'd15886;
      7'd30: v = 16'd16384;   7'd31: v = 16'd16877;   7'd32: v = 16'd17364;
      7'd33: v = 16'd17847;   7'd34: v = 16'd18324;   7'd35: v = 16'd18795;
      7'd36: v = 16'd19261;   7'd37: v = 16'd19720;   7'd38: v = 16'd20174;
      7'd39: v = 16'd20622;   7'd40: v = 16'd21063;   7'd41: v = 16'd21498;
      7'd42: v = 16'd21926;   7'd43: v = 16'd22348;   7'd44: v = 16'd22763;
      7'd45: v = 16'd23170;   7'd46: v = 16'd23571;   7'd47: v = 16'd23965;
      7'd48: v = 16'd24351;   7'd49: v = 16'd24730;   7'd50: v = 16'd25102;
      7'd51: v = 16'd25466;   7'd52: v = 16'd25822;   7'd53: v = 16'd26170;
      7'd54: v = 16'd26510;   7'd55: v = 16'd26842;   7'd56: v = 16'd27166;
      7'd57: v = 16'd27482;   7'd58: v = 16'd27789;   7'd59: v = 16'd28088;
      7'd60: v = 16'd28378;   7'd61: v = 16'd28660;   7'd62: v = 16'd28932;
      7'd63: v = 16'd29197;   7'd64: v = 16'd29452;   7'd65: v = 16'd29698;
      7'd66: v = 16'd29935;   7'd67: v = 16'd30163;   7'd68: v = 16'd30382;
      7'd69: v = 16'd30592;   7'd70: v = 16'd30792;   7'd71: v = 16'd30983;
      7'd72: v = 16'd31164;   7'd73: v = 16'd31336;   7'd74: v = 16'd31499;
      7'd75: v = 16'd31651;   7'd76: v = 16'd31795;   7'd77: v = 16'd31928;
      7'd78: v = 16'd32052;   7'd79: v = 16'd32166;   7'd80: v = 16'd32270;
      7'd81: v = 16'd32365;   7'd82: v = 16'd32449;   7'd83: v = 16'd32524;
      7'd84: v = 16'd32588;   7'd85: v = 16'd32643;   7'd86: v = 16'd32688;
      7'd87: v = 16'd32723;   7'd88: v = 16'd32748;   7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Sine of a whole degree 0..359 in Q2.15, by quadrant symmetry.
  function automatic logic signed [16:0] sine_degree(input logic [8:0] d);
    logic [8:0] idx;
    logic neg;
    logic signed [16:0] mag;
    if (d <= 9'd90) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = d - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - d;
      neg = 1'b1;
    end
    mag = $signed({1'b0, quarter_sine(idx[6:0])});
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fffffff;
    if (v < -43'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: src/knee_assist_torque_delay_top.sv
// Top level of the knee assist torque delay block: sequencer around one shared multiplier.
// Depends on kat_pkg, kat_mul and kat_dline.
//
//   channel | direction | payload
//   in_     | slave     | four 17 bit pitch angles
//   out_    | master    | four 32 bit saturated torques
//   cfg_    | write     | register index and 18 bit data
//
// A frame runs from one input transfer to the next, plus output wait, through the filter,
// wrap, sine, delay line and torque states. The wrap state steps both filtered angles by
// 360 degrees (one compare and add per cycle, at most three per side for the widest
// angles), and the shared multiplier serves the filter, sine and torque steps in turn.
// Reset clears the filter state, write position, fill count, offsets and delay; delay line
// entries not yet written read as zero through the fill count. The output register
// holds a result while out_tready is low, and the next frame is taken after it leaves.
module knee_assist_torque_delay_top
  import kat_pkg::*;
#(
  parameter int DELAY_DEPTH = 100
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // left_thigh_angle, left_shank_angle, right_thigh_angle, right_shank_angle (17 each)
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_walk_torque, right_walk_torque, left_stair_torque, right_stair_torque (32 each)
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [17:0]  cfg_data
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = ((AW > 7) ? AW : 7) + 2;
  localparam int NW = $clog2(DELAY_DEPTH + 1);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FA   = 15'h0002,
    S_FB   = 15'h0004,
    S_FC   = 15'h0008,
    S_WRAP = 15'h0010,
    S_SA   = 15'h0020,
    S_SB   = 15'h0040,
    S_WR   = 15'h0080,
    S_RD   = 15'h0100,
    S_WL   = 15'h0200,
    S_WRT  = 15'h0400,
    S_SL   = 15'h0800,
    S_SR   = 15'h1000,
    S_SRD  = 15'h2000,
    S_OUT  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [17:0] lofs_r, rofs_r;
  logic [15:0] ext_r, flex_r;
  logic [6:0] dly_r;

  logic signed [19:0] lk_r, rk_r, lk_nxt, rk_nxt;
  logic signed [21:0] lf_r, rf_r;
  logic side_r;
  logic signed [41:0] acc_r;
  logic signed [22:0] ang_r;
  logic signed [16:0] s0_r, sl_r, sr_r;
  logic [AW-1:0] wp_r, rd_r;
  logic [NW-1:0] cnt_r;
  logic vld_r;
  logic signed [31:0] lw_r, rw_r, stl_r, str_r;
  logic out_valid_r;
  logic [127:0] out_data_r;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] p_r;

  line_entry_t wentry, rentry_r, entry;

  kat_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  kat_dline #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_dline (
    .clk(clk), .we(state_r == S_WR), .waddr(wp_r), .wdata(wentry),
    .re(state_r == S_RD), .raddr(rd_r), .rdata_r(rentry_r)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign lk_nxt = 20'($signed(in_tdata[33:17])) - 20'($signed(in_tdata[16:0])) - 20'(lofs_r);
  assign rk_nxt = 20'($signed(in_tdata[67:51])) - 20'($signed(in_tdata[50:34]))
                  - 20'(rofs_r);

  // Entries beyond the fill count were never written and read as zero.
  assign entry = vld_r ? rentry_r : '0;

  logic signed [16:0] s0_c, s1_c;
  logic [8:0] deg, deg1;
  assign deg = ang_r[16:8];
  assign deg1 = (deg == 9'd359) ? 9'd0 : deg + 9'd1;
  assign s0_c = sine_degree(deg);
  assign s1_c = sine_degree(deg1);

  logic signed [41:0] filt_sum;
  logic signed [25:0] sine_sum;
  assign filt_sum = acc_r + 42'(p_r) + 42'sd32768;
  assign sine_sum = $signed({s0_r, 8'd0}) + 26'(p_r) + 26'sd128;

  logic in_band_pos, in_band_neg;
  logic [15:0] gain_l, gain_r;
  assign in_band_pos = !entry.diff[DIFF_W-1] && (entry.diff < BAND_LIMIT);
  assign in_band_neg = entry.diff[DIFF_W-1] && (entry.diff > -BAND_LIMIT);
  assign gain_l = in_band_pos ? ext_r : (in_band_neg ? flex_r : 16'd0);
  assign gain_r = in_band_pos ? flex_r : (in_band_neg ? ext_r : 16'd0);

  function automatic logic signed [31:0] stair_torque(input logic signed [MUL_PW-1:0] p,
                                                       input logic pos);
    logic signed [42:0] w;
    w = 43'(p);
    return sat32(pos ? (w + (w <<< 2)) : (w >>> 1));
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FA: begin
        mul_a = 23'(side_r ? rf_r : lf_r);
        mul_b = COEF_KEEP;
      end
      S_FB: begin
        mul_a = 23'(side_r ? rk_r : lk_r);
        mul_b = COEF_NEW;
      end
      S_SA: begin
        mul_a = 23'(s1_c - s0_c);
        mul_b = $signed({9'd0, ang_r[7:0]});
      end
      S_WL: begin
        mul_a = 23'(entry.walk);
        mul_b = $signed({1'b0, gain_l});
      end
      S_WRT: begin
        mul_a = 23'(entry.walk);
        mul_b = $signed({1'b0, gain_r});
      end
      S_SL: begin
        mul_a = 23'(entry.stair_l);
        mul_b = $signed({1'b0, (entry.stair_l > 0) ? ext_r : flex_r});
      end
      S_SR: begin
        mul_a = 23'(entry.stair_r);
        mul_b = $signed({1'b0, (entry.stair_r > 0) ? ext_r : flex_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    wentry.walk = 18'(sr_r) - 18'(sl_r);
    wentry.diff = 23'(rf_r) - 23'(lf_r);
    wentry.stair_l = 20'(sl_r) - 20'(sr_r) * 20'sd5;
    wentry.stair_r = 20'(sr_r) - 20'(sl_r) * 20'sd5;
  end

  // Read index from the write position and the clamped delay.
  logic [CW-1:0] dp_c, wp_c, rd_c;
  logic [NW-1:0] cnt_nxt;
  always_comb begin
    dp_c = CW'(dly_r);
    if (dp_c >= CW'(DELAY_DEPTH)) begin
      dp_c = CW'(DELAY_DEPTH - 1);
    end
    wp_c = CW'(wp_r);
    rd_c = (wp_c >= dp_c) ? wp_c - dp_c : wp_c + CW'(DELAY_DEPTH) - dp_c;
    cnt_nxt = (cnt_r == NW'(DELAY_DEPTH)) ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_FA;
      S_FA:   state_nxt = S_FB;
      S_FB:   state_nxt = S_FC;
      S_FC:   state_nxt = S_WRAP;
      S_WRAP: if (!ang_r[22] && ang_r < FULL_TURN) state_nxt = S_SA;
      S_SA:   state_nxt = S_SB;
      S_SB:   state_nxt = side_r ? S_WR : S_FA;
      S_WR:   state_nxt = S_RD;
      S_RD:   state_nxt = S_WL;
      S_WL:   state_nxt = S_WRT;
      S_WRT:  state_nxt = S_SL;
      S_SL:   state_nxt = S_SR;
      S_SR:   state_nxt = S_SRD;
      S_SRD:  state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lofs_r <= '0;
      rofs_r <= '0;
      ext_r <= 16'd256;
      flex_r <= 16'd256;
      dly_r <= '0;
      lf_r <= '0;
      rf_r <= '0;
      wp_r <= '0;
      cnt_r <= '0;
      side_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          REG_LEFT_OFFSET:  lofs_r <= $signed(cfg_data);
          REG_RIGHT_OFFSET: rofs_r <= $signed(cfg_data);
          REG_EXT_GAIN:     ext_r <= cfg_data[15:0];
          REG_FLEX_GAIN:    flex_r <= cfg_data[15:0];
          REG_DELAY_POINTS: dly_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: side_r <= 1'b0;
        S_FC: begin
          if (side_r) rf_r <= filt_sum[37:16];
          else lf_r <= filt_sum[37:16];
        end
        S_SB: side_r <= 1'b1;
        S_WR: begin
          wp_r <= (wp_c == CW'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          cnt_r <= cnt_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        lk_r <= lk_nxt;
        rk_r <= rk_nxt;
      end
      S_FB: acc_r <= 42'(p_r);
      S_FC: ang_r <= 23'($signed(filt_sum[37:16]));
      S_WRAP: begin
        if (ang_r[22]) ang_r <= ang_r + FULL_TURN;
        else if (ang_r >= FULL_TURN) ang_r <= ang_r - FULL_TURN;
      end
      S_SA: s0_r <= s0_c;
      S_SB: begin
        if (side_r) sr_r <= sine_sum[24:8];
        else sl_r <= sine_sum[24:8];
      end
      S_WR: begin
        rd_r <= rd_c[AW-1:0];
        vld_r <= (NW + 1)'(rd_c) < (NW + 1)'(cnt_nxt);
      end
      S_WRT: lw_r <= sat32(-43'(p_r));
      S_SL: rw_r <= sat32(43'(p_r));
      S_SR: stl_r <= stair_torque(p_r, entry.stair_l > 0);
      S_SRD: str_r <= stair_torque(p_r, entry.stair_r > 0);
      S_OUT: if (!out_valid_r || out_tready) out_data_r <= {str_r, stl_r, rw_r, lw_r};
      default: ;
    endcase
  end

endmodule

FILE: src/kat_mul.sv
// Shared signed multiplier with a registered product.
// Depends on kat_pkg for the operand widths.
module kat_mul
  import kat_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

FILE: src/kat_dline.sv
// Delay line memory: one write port and one registered read port.
// Depends on kat_pkg for the entry layout.
module kat_dline
  import kat_pkg::*;
#(
  parameter int DEPTH = 100,
  parameter int AW = 7
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] waddr,
  input  line_entry_t wdata,
  input  logic        re,
  input  logic [AW-1:0] raddr,
  output line_entry_t rdata_r
);

  line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
